// File: rtl/cbs_pkg.sv
// Shared types, codes and constants of the color box sorter sequencer.
package cbs_pkg;

  // Width of every pulse-width and timer field.
  localparam int FIELD_W = 16;

  // Default saturation width of the pulse-width inputs.
  localparam int PULSE_WIDTH_BITS_DEF = 16;

  // Configuration register indexes.
  localparam logic [2:0] CFG_PUSH_PERIOD = 3'd0;
  localparam logic [2:0] CFG_SCAN_TIME   = 3'd1;
  localparam logic [2:0] CFG_SHOW_TIME   = 3'd2;
  localparam logic [2:0] CFG_SORT_SETTLE = 3'd3;
  localparam logic [2:0] CFG_GATE_OPEN   = 3'd4;

  // Configuration reset values.
  localparam logic [FIELD_W-1:0] PUSH_PERIOD_RST = 16'd2000;
  localparam logic [FIELD_W-1:0] SCAN_TIME_RST   = 16'd2000;
  localparam logic [FIELD_W-1:0] SHOW_TIME_RST   = 16'd3000;
  localparam logic [FIELD_W-1:0] SORT_SETTLE_RST = 16'd1000;
  localparam logic [FIELD_W-1:0] GATE_OPEN_RST   = 16'd2000;

  // Timer ceiling and dark threshold.
  localparam logic [FIELD_W-1:0] TIMER_MAX = 16'hFFFF;
  localparam logic [FIELD_W-1:0] DARK_MAX  = 16'd8;

  // Class codes shared by sensor labels and the combined class.
  localparam logic [2:0] CL_NONE    = 3'd0;
  localparam logic [2:0] CL_RED     = 3'd1;
  localparam logic [2:0] CL_YELLOW  = 3'd2;
  localparam logic [2:0] CL_GREEN   = 3'd3;
  localparam logic [2:0] CL_STRIPED = 3'd4;

  // Phase codes as seen on the result channel.
  localparam logic [2:0] PHC_HOME = 3'd0;
  localparam logic [2:0] PHC_SCAN = 3'd1;
  localparam logic [2:0] PHC_SHOW = 3'd2;
  localparam logic [2:0] PHC_SORT = 3'd3;
  localparam logic [2:0] PHC_GATE = 3'd4;

  // Sorter rest position (135 degrees).
  localparam logic [1:0] SORTER_HOME = 2'd3;

  // Sequencer phase, one-hot.
  typedef enum logic [4:0] {
    PH_HOME = 5'b00001,
    PH_SCAN = 5'b00010,
    PH_SHOW = 5'b00100,
    PH_SORT = 5'b01000,
    PH_GATE = 5'b10000
  } phase_t;

  // Input request payload.
  typedef struct packed {
    logic               command;
    logic [FIELD_W-1:0] red_right;
    logic [FIELD_W-1:0] green_right;
    logic [FIELD_W-1:0] blue_right;
    logic [FIELD_W-1:0] red_left;
    logic [FIELD_W-1:0] green_left;
    logic [FIELD_W-1:0] blue_left;
  } cbs_in_t;

  // Result request payload.
  typedef struct packed {
    logic [2:0] phase;
    logic       pusher_on;
    logic [1:0] sorter_position;
    logic       gate_open;
    logic [2:0] right_class;
    logic [2:0] left_class;
    logic [2:0] scan_class;
    logic       conveyor_stop;
  } cbs_out_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [FIELD_W-1:0] push_period;
    logic [FIELD_W-1:0] scan_time;
    logic [FIELD_W-1:0] show_time;
    logic [FIELD_W-1:0] sort_settle;
    logic [FIELD_W-1:0] gate_open;
  } cbs_cfg_t;

  // One bounding box: inclusive low and high limits per color.
  typedef struct packed {
    logic [7:0] r_lo;
    logic [7:0] r_hi;
    logic [7:0] g_lo;
    logic [7:0] g_hi;
    logic [7:0] b_lo;
    logic [7:0] b_hi;
  } cbs_bound_t;

  // Boxes of one sensor: index 0 red, 1 yellow, 2 green.
  typedef cbs_bound_t [2:0] cbs_box_t;

  localparam cbs_box_t BOX_RIGHT = '{
    '{8'd20, 8'd35,  8'd22,  8'd32,  8'd35,  8'd47},
    '{8'd15, 8'd85,  8'd30,  8'd61,  8'd30,  8'd96},
    '{8'd15, 8'd130, 8'd60,  8'd160, 8'd50,  8'd140}
  };

  localparam cbs_box_t BOX_LEFT = '{
    '{8'd25, 8'd55,  8'd30,  8'd60,  8'd60,  8'd85},
    '{8'd15, 8'd40,  8'd43,  8'd75,  8'd60,  8'd95},
    '{8'd19, 8'd55,  8'd110, 8'd155, 8'd100, 8'd135}
  };

  // Classifier verdict for one sensor: first matching box and darkness.
  typedef struct packed {
    logic [2:0] hit;
    logic       dark;
  } cbs_sense_t;

  // Map the one-hot phase to its result code.
  function automatic logic [2:0] phase_code(phase_t ph);
    logic [2:0] code;
    case (ph)
      PH_HOME: code = PHC_HOME;
      PH_SCAN: code = PHC_SCAN;
      PH_SHOW: code = PHC_SHOW;
      PH_SORT: code = PHC_SORT;
      PH_GATE: code = PHC_GATE;
      default: code = PHC_HOME;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/color_box_sorter_sequencer_core.sv
// Top level of the color box sorter sequencer: input and result registers, config.
//
//  Channel   Ports                          Direction  Carries
//  input     in_valid, in_ready, in_data    in         tick or two-sensor RGB sample
//  result    out_valid, out_ready, out_data out        phase, servos, classes, stop
//  config    cfg_we, cfg_index, cfg_wdata   in         timing registers, write only
//
// One request per cycle is sustained while the result channel does not stall; a result is
// presented after its request is accepted (input register, then classification and phase
// update into the result register). The phase state is registered and feeds back to the
// next request, so consecutive requests chain without gaps.
// Synchronous active-low reset clears the sequencer and loads the register defaults.
// A stalled result register holds; the input register still takes one more request.
module color_box_sorter_sequencer_core #(
  parameter int PULSE_WIDTH_BITS = cbs_pkg::PULSE_WIDTH_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  cbs_pkg::cbs_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cbs_pkg::cbs_out_t           out_data,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [cbs_pkg::FIELD_W-1:0] cfg_wdata
);

  logic                s1_valid_r, s1_valid_nxt;
  cbs_pkg::cbs_in_t    s1_data_r;
  logic                out_valid_r, out_valid_nxt;
  cbs_pkg::cbs_out_t   out_data_r;
  cbs_pkg::cbs_cfg_t   cfg_r;
  cbs_pkg::cbs_sense_t right_sense;
  cbs_pkg::cbs_sense_t left_sense;
  cbs_pkg::cbs_out_t   result;
  logic                advance;

  // The input stage moves on when the result register is free or draining.
  assign advance       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready      = !s1_valid_r || advance;
  assign s1_valid_nxt  = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // Handshake state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.push_period <= cbs_pkg::PUSH_PERIOD_RST;
      cfg_r.scan_time   <= cbs_pkg::SCAN_TIME_RST;
      cfg_r.show_time   <= cbs_pkg::SHOW_TIME_RST;
      cfg_r.sort_settle <= cbs_pkg::SORT_SETTLE_RST;
      cfg_r.gate_open   <= cbs_pkg::GATE_OPEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cbs_pkg::CFG_PUSH_PERIOD: cfg_r.push_period <= cfg_wdata;
        cbs_pkg::CFG_SCAN_TIME:   cfg_r.scan_time   <= cfg_wdata;
        cbs_pkg::CFG_SHOW_TIME:   cfg_r.show_time   <= cfg_wdata;
        cbs_pkg::CFG_SORT_SETTLE: cfg_r.sort_settle <= cfg_wdata;
        cbs_pkg::CFG_GATE_OPEN:   cfg_r.gate_open   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Right and left sensor classifiers.
  cbs_classifier #(.PULSE_WIDTH_BITS(PULSE_WIDTH_BITS)) u_right (
    .red   (s1_data_r.red_right),
    .green (s1_data_r.green_right),
    .blue  (s1_data_r.blue_right),
    .box   (cbs_pkg::BOX_RIGHT),
    .sense (right_sense)
  );

  cbs_classifier #(.PULSE_WIDTH_BITS(PULSE_WIDTH_BITS)) u_left (
    .red   (s1_data_r.red_left),
    .green (s1_data_r.green_left),
    .blue  (s1_data_r.blue_left),
    .box   (cbs_pkg::BOX_LEFT),
    .sense (left_sense)
  );

  // Phase sequencer and class state.
  cbs_sequencer u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .is_sample   (s1_data_r.command),
    .right_sense (right_sense),
    .left_sense  (left_sense),
    .cfg         (cfg_r),
    .result      (result)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/cbs_classifier.sv
// Bounding-box color classifier for one sensor.
module cbs_classifier #(
  parameter int PULSE_WIDTH_BITS = cbs_pkg::PULSE_WIDTH_BITS_DEF
) (
  input  logic [cbs_pkg::FIELD_W-1:0] red,
  input  logic [cbs_pkg::FIELD_W-1:0] green,
  input  logic [cbs_pkg::FIELD_W-1:0] blue,
  input  cbs_pkg::cbs_box_t           box,
  output cbs_pkg::cbs_sense_t         sense
);

  localparam int FW = cbs_pkg::FIELD_W;
  localparam logic [FW-1:0] SAT_MAX = (PULSE_WIDTH_BITS >= FW) ? {FW{1'b1}} :
                                      FW'((64'd1 << PULSE_WIDTH_BITS) - 64'd1);

  logic [FW-1:0] r_sat;
  logic [FW-1:0] g_sat;
  logic [FW-1:0] b_sat;
  logic [2:0]    in_box;

  // Saturate the widths to the configured pulse-width range.
  assign r_sat = (red   > SAT_MAX) ? SAT_MAX : red;
  assign g_sat = (green > SAT_MAX) ? SAT_MAX : green;
  assign b_sat = (blue  > SAT_MAX) ? SAT_MAX : blue;

  // Test all three boxes in parallel.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_box[k] = (r_sat >= FW'(box[k].r_lo)) && (r_sat <= FW'(box[k].r_hi)) &&
                  (g_sat >= FW'(box[k].g_lo)) && (g_sat <= FW'(box[k].g_hi)) &&
                  (b_sat >= FW'(box[k].b_lo)) && (b_sat <= FW'(box[k].b_hi));
    end
  end

  // Keep only the first match: red before yellow before green.
  assign sense.hit[0] = in_box[0];
  assign sense.hit[1] = in_box[1] && !in_box[0];
  assign sense.hit[2] = in_box[2] && !in_box[1] && !in_box[0];

  // A reading is dark when every channel is at or below the threshold.
  assign sense.dark = (r_sat <= cbs_pkg::DARK_MAX) && (g_sat <= cbs_pkg::DARK_MAX) &&
                      (b_sat <= cbs_pkg::DARK_MAX);

endmodule

// File: rtl/cbs_sequencer.sv
// Phase sequencer, class state and result formation of the sorter.
module cbs_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                is_sample,
  input  cbs_pkg::cbs_sense_t right_sense,
  input  cbs_pkg::cbs_sense_t left_sense,
  input  cbs_pkg::cbs_cfg_t   cfg,
  output cbs_pkg::cbs_out_t   result
);

  localparam int FW = cbs_pkg::FIELD_W;

  cbs_pkg::phase_t phase_r, phase_nxt;
  logic            pusher_r, pusher_nxt;
  logic [FW-1:0]   push_timer_r, push_timer_nxt;
  logic [FW-1:0]   phase_timer_r, phase_timer_nxt;
  logic [2:0]      right_flags_r, right_flags_nxt;
  logic [2:0]      left_flags_r, left_flags_nxt;
  logic [2:0]      right_label_r, right_label_nxt;
  logic [2:0]      left_label_r, left_label_nxt;
  logic [2:0]      scan_r, scan_nxt;
  logic [2:0]      held_r, held_nxt;
  logic [1:0]      sorter_r, sorter_nxt;
  logic            stop_r, stop_nxt;

  logic [2:0]      r_flags_s, l_flags_s;
  logic [2:0]      r_label_s, l_label_s;
  logic [2:0]      all_flags;
  logic [2:0]      scan_s;
  logic            stop_s;
  logic [FW-1:0]   push_inc;
  logic [FW-1:0]   phase_inc;
  logic [2:0]      held_m1;

  // Sample classification: new flags and labels for both sensors.
  always_comb begin
    r_flags_s = right_flags_r;
    r_label_s = cbs_pkg::CL_NONE;
    if (right_sense.hit != 3'b000) begin
      r_flags_s = right_sense.hit;
      r_label_s = right_sense.hit[0] ? cbs_pkg::CL_RED :
                  right_sense.hit[1] ? cbs_pkg::CL_YELLOW : cbs_pkg::CL_GREEN;
    end else if (!right_sense.dark) begin
      r_flags_s = 3'b000;
      r_label_s = cbs_pkg::CL_STRIPED;
    end

    l_flags_s = left_flags_r;
    l_label_s = cbs_pkg::CL_NONE;
    if (left_sense.hit != 3'b000) begin
      l_flags_s = left_sense.hit;
      l_label_s = left_sense.hit[0] ? cbs_pkg::CL_RED :
                  left_sense.hit[1] ? cbs_pkg::CL_YELLOW : cbs_pkg::CL_GREEN;
    end else if (!left_sense.dark) begin
      l_flags_s = 3'b000;
      l_label_s = cbs_pkg::CL_STRIPED;
    end
  end

  // Combined class from the OR of both sensors' flags.
  assign all_flags = r_flags_s | l_flags_s;
  assign stop_s    = !((r_label_s == cbs_pkg::CL_NONE) && (l_label_s == cbs_pkg::CL_NONE));
  assign scan_s    = !stop_s      ? cbs_pkg::CL_NONE   :
                     all_flags[0] ? cbs_pkg::CL_RED    :
                     all_flags[1] ? cbs_pkg::CL_YELLOW :
                     all_flags[2] ? cbs_pkg::CL_GREEN  : cbs_pkg::CL_STRIPED;

  // Saturating timer increments.
  assign push_inc  = (push_timer_r  == cbs_pkg::TIMER_MAX) ? cbs_pkg::TIMER_MAX :
                     push_timer_r + FW'(1);
  assign phase_inc = (phase_timer_r == cbs_pkg::TIMER_MAX) ? cbs_pkg::TIMER_MAX :
                     phase_timer_r + FW'(1);
  assign held_m1   = held_r - 3'd1;

  // Next state for one request.
  always_comb begin
    phase_nxt       = phase_r;
    pusher_nxt      = pusher_r;
    push_timer_nxt  = push_timer_r;
    phase_timer_nxt = phase_timer_r;
    right_flags_nxt = right_flags_r;
    left_flags_nxt  = left_flags_r;
    right_label_nxt = right_label_r;
    left_label_nxt  = left_label_r;
    scan_nxt        = scan_r;
    held_nxt        = held_r;
    sorter_nxt      = sorter_r;
    stop_nxt        = stop_r;

    if (!is_sample) begin
      if (phase_r == cbs_pkg::PH_HOME) begin
        // Pusher toggles once per period.
        if (push_inc >= cfg.push_period) begin
          pusher_nxt     = !pusher_r;
          push_timer_nxt = '0;
        end else begin
          push_timer_nxt = push_inc;
        end
      end else begin
        phase_timer_nxt = phase_inc;
        case (phase_r)
          cbs_pkg::PH_SHOW: begin
            if (phase_inc >= cfg.show_time) begin
              phase_nxt       = cbs_pkg::PH_SORT;
              phase_timer_nxt = '0;
              if (held_r != cbs_pkg::CL_NONE) begin
                sorter_nxt = held_m1[1:0];
              end
            end
          end
          cbs_pkg::PH_SORT: begin
            if (phase_inc >= cfg.sort_settle) begin
              phase_nxt       = cbs_pkg::PH_GATE;
              phase_timer_nxt = '0;
            end
          end
          cbs_pkg::PH_GATE: begin
            if (phase_inc >= cfg.gate_open) begin
              phase_nxt       = cbs_pkg::PH_HOME;
              phase_timer_nxt = '0;
              push_timer_nxt  = '0;
              sorter_nxt      = cbs_pkg::SORTER_HOME;
            end
          end
          default: begin
          end
        endcase
      end
    end else if ((phase_r == cbs_pkg::PH_HOME) || (phase_r == cbs_pkg::PH_SCAN)) begin
      // Samples count only while home or scanning.
      right_flags_nxt = r_flags_s;
      left_flags_nxt  = l_flags_s;
      right_label_nxt = r_label_s;
      left_label_nxt  = l_label_s;
      scan_nxt        = scan_s;
      stop_nxt        = stop_s;
      if (phase_r == cbs_pkg::PH_HOME) begin
        if (stop_s) begin
          phase_nxt       = cbs_pkg::PH_SCAN;
          push_timer_nxt  = '0;
          phase_timer_nxt = '0;
        end
      end else if (phase_timer_r > cfg.scan_time) begin
        phase_nxt       = cbs_pkg::PH_SHOW;
        phase_timer_nxt = '0;
        held_nxt        = scan_s;
      end
    end
  end

  // State registers advance once per request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= cbs_pkg::PH_HOME;
      pusher_r      <= 1'b0;
      push_timer_r  <= '0;
      phase_timer_r <= '0;
      right_flags_r <= 3'b000;
      left_flags_r  <= 3'b000;
      right_label_r <= cbs_pkg::CL_NONE;
      left_label_r  <= cbs_pkg::CL_NONE;
      scan_r        <= cbs_pkg::CL_NONE;
      held_r        <= cbs_pkg::CL_NONE;
      sorter_r      <= cbs_pkg::SORTER_HOME;
      stop_r        <= 1'b0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      pusher_r      <= pusher_nxt;
      push_timer_r  <= push_timer_nxt;
      phase_timer_r <= phase_timer_nxt;
      right_flags_r <= right_flags_nxt;
      left_flags_r  <= left_flags_nxt;
      right_label_r <= right_label_nxt;
      left_label_r  <= left_label_nxt;
      scan_r        <= scan_nxt;
      held_r        <= held_nxt;
      sorter_r      <= sorter_nxt;
      stop_r        <= stop_nxt;
    end
  end

  // Result reflects the state after this request.
  assign result.phase           = cbs_pkg::phase_code(phase_nxt);
  assign result.pusher_on       = (phase_nxt == cbs_pkg::PH_HOME) && pusher_nxt;
  assign result.sorter_position = sorter_nxt;
  assign result.gate_open       = (phase_nxt == cbs_pkg::PH_GATE);
  assign result.right_class     = right_label_nxt;
  assign result.left_class      = left_label_nxt;
  assign result.scan_class      = scan_nxt;
  assign result.conveyor_stop   = stop_nxt;

`ifndef NO_ASSERTIONS
  // The sorter rests at its home angle until the sort settle phase.
  a_sorter_home: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == cbs_pkg::PH_HOME) || (phase_r == cbs_pkg::PH_SCAN) ||
     (phase_r == cbs_pkg::PH_SHOW)) |-> (sorter_r == cbs_pkg::SORTER_HOME))
    else $error("sorter left home position outside sort and gate phases");

  // The stop flag is set exactly when some sensor sees an object.
  a_stop_labels: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r == !((right_label_r == cbs_pkg::CL_NONE) && (left_label_r == cbs_pkg::CL_NONE)))
    else $error("stop flag disagrees with sensor labels");

  // Without an object the combined class is none.
  a_scan_none: assert property (@(posedge clk) disable iff (!rst_n)
    !stop_r |-> (scan_r == cbs_pkg::CL_NONE))
    else $error("combined class set while conveyor runs");

  // Returning home clears both timers and parks the sorter.
  a_return_home: assert property (@(posedge clk) disable iff (!rst_n)
    (step && (phase_r == cbs_pkg::PH_GATE) && (phase_nxt == cbs_pkg::PH_HOME)) |=>
    ((push_timer_r == '0) && (phase_timer_r == '0) && (sorter_r == cbs_pkg::SORTER_HOME)))
    else $error("return to home did not clear timers or park sorter");

  // Without a request the phase and held result stay put.
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> ($stable(phase_r) && $stable(held_r)))
    else $error("sequencer state moved without a request");
`endif

endmodule
